### rtl/acsd_pkg.sv
// acsd_pkg: shared types, codes and segment helpers for the alarm clock set controller
package acsd_pkg;

    // button / tick codes carried in the op field
    typedef enum logic [2:0] {
        OP_TICK = 3'd0,
        OP_MODE = 3'd1,
        OP_EDIT = 3'd2,
        OP_INC  = 3'd3,
        OP_DEC  = 3'd4
    } op_t;

    // screen modes
    typedef enum logic [2:0] {
        MODE_TIME       = 3'd0,
        MODE_ALARM      = 3'd1,
        MODE_TEMP       = 3'd2,
        MODE_EDIT_HOUR  = 3'd3,
        MODE_EDIT_MIN   = 3'd4,
        MODE_EDIT_AHOUR = 3'd5,
        MODE_EDIT_AMIN  = 3'd6
    } mode_t;

    // wrap limits for hour and minute, clamp limit for temperature
    localparam logic [5:0] HOUR_MAX   = 6'd23;
    localparam logic [5:0] MINUTE_MAX = 6'd59;
    localparam logic [6:0] TEMP_MAX   = 7'd99;

    // fixed active-low glyphs
    localparam logic [7:0] SEG_BLANK  = 8'hff;
    localparam logic [7:0] SEG_GLYPH_C   = ~8'h39;
    localparam logic [7:0] SEG_GLYPH_DEG = ~8'h63;

    // input transaction
    typedef struct packed {
        logic [2:0] op;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
        logic [5:0] now_second;
        logic [6:0] temperature;
        logic       blink_phase;
    } evt_t;

    // result transaction
    typedef struct packed {
        logic [7:0] seg_0;
        logic [7:0] seg_1;
        logic [7:0] seg_2;
        logic [7:0] seg_3;
        logic [7:0] seg_4;
        logic [7:0] seg_5;
        logic [2:0] mode_now;
        logic       alarm_armed;
        logic       rtc_write;
        logic [4:0] write_hour;
        logic [5:0] write_minute;
    } disp_t;

    // controller state
    typedef struct packed {
        mode_t      mode;
        logic [4:0] edit_hour;
        logic [5:0] edit_minute;
        logic [4:0] alarm_hour;
        logic [5:0] alarm_minute;
        logic       alarm_enabled;
    } state_t;

    localparam state_t STATE_RESET = '{
        mode:          MODE_TIME,
        edit_hour:     5'd0,
        edit_minute:   6'd0,
        alarm_hour:    5'd2,
        alarm_minute:  6'd5,
        alarm_enabled: 1'b1
    };

    // controller to renderer
    typedef struct packed {
        state_t st;
        logic   rtc_write;
    } ctrl_out_t;

    // step up with wrap to zero past top
    function automatic logic [5:0] step_up(input logic [5:0] v, input logic [5:0] top);
        return (v >= top) ? 6'd0 : v + 6'd1;
    endfunction

    // step down with wrap to top; out-of-range values land on top
    function automatic logic [5:0] step_down(input logic [5:0] v, input logic [5:0] top);
        return ((v == 6'd0) || (v > top)) ? top : v - 6'd1;
    endfunction

    // active-low code of one digit with optional decimal point
    function automatic logic [7:0] seg_code(input logic [3:0] digit, input logic dp);
        logic [7:0] pat;
        case (digit)
            4'd0: pat = 8'h3f;
            4'd1: pat = 8'h06;
            4'd2: pat = 8'h5b;
            4'd3: pat = 8'h4f;
            4'd4: pat = 8'h66;
            4'd5: pat = 8'h6d;
            4'd6: pat = 8'h7d;
            4'd7: pat = 8'h07;
            4'd8: pat = 8'h7f;
            4'd9: pat = 8'h6f;
            default: pat = 8'h00;
        endcase
        pat[7] = dp;
        return ~pat;
    endfunction

    // two-digit pair {tens, ones}; divide by ten via multiply by 205 >> 11
    function automatic logic [15:0] pair_codes(input logic [6:0] v, input logic dp,
                                               input logic blank);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        logic [3:0]  ones;
        prod     = 15'(v) * 15'd205;
        tens     = prod[14:11];
        tens_x10 = 7'(tens) * 7'd10;
        ones     = 4'(v - tens_x10);
        if (blank)
        begin
            return {SEG_BLANK, SEG_BLANK};
        end
        return {seg_code(tens, 1'b0), seg_code(ones, dp)};
    endfunction

endpackage

### rtl/acsd_ctrl.sv
// acsd_ctrl: mode and edit state registers with next-state logic per event
module acsd_ctrl
    import acsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  evt_t      evt,
    output ctrl_out_t ctrl
);

    state_t state_reg;
    state_t state_next;
    logic   wr;

    // event decode and field stepping
    always_comb
    begin
        state_next = state_reg;
        wr         = 1'b0;
        case (evt.op)
            OP_MODE:
            begin
                case (state_reg.mode)
                    MODE_TIME:  state_next.mode = MODE_ALARM;
                    MODE_ALARM: state_next.mode = MODE_TEMP;
                    default:    state_next.mode = MODE_TIME;
                endcase
            end
            OP_EDIT:
            begin
                case (state_reg.mode)
                    MODE_TIME:
                    begin
                        state_next.mode        = MODE_EDIT_HOUR;
                        state_next.edit_hour   = ({1'b0, evt.now_hour} > HOUR_MAX) ?
                                                 5'd0 : evt.now_hour;
                        state_next.edit_minute = (evt.now_minute > MINUTE_MAX) ?
                                                 6'd0 : evt.now_minute;
                    end
                    MODE_ALARM:      state_next.mode = MODE_EDIT_AHOUR;
                    MODE_EDIT_HOUR:  state_next.mode = MODE_EDIT_MIN;
                    MODE_EDIT_MIN:
                    begin
                        state_next.mode = MODE_TIME;
                        wr              = 1'b1;
                    end
                    MODE_EDIT_AHOUR: state_next.mode = MODE_EDIT_AMIN;
                    MODE_EDIT_AMIN:  state_next.mode = MODE_ALARM;
                    default:         ;
                endcase
            end
            OP_INC:
            begin
                case (state_reg.mode)
                    MODE_ALARM:      state_next.alarm_enabled = 1'b1;
                    MODE_EDIT_HOUR:  state_next.edit_hour =
                                         5'(step_up({1'b0, state_reg.edit_hour}, HOUR_MAX));
                    MODE_EDIT_MIN:   state_next.edit_minute =
                                         step_up(state_reg.edit_minute, MINUTE_MAX);
                    MODE_EDIT_AHOUR: state_next.alarm_hour =
                                         5'(step_up({1'b0, state_reg.alarm_hour}, HOUR_MAX));
                    MODE_EDIT_AMIN:  state_next.alarm_minute =
                                         step_up(state_reg.alarm_minute, MINUTE_MAX);
                    default:         ;
                endcase
            end
            OP_DEC:
            begin
                case (state_reg.mode)
                    MODE_ALARM:      state_next.alarm_enabled = 1'b0;
                    MODE_EDIT_HOUR:  state_next.edit_hour =
                                         5'(step_down({1'b0, state_reg.edit_hour}, HOUR_MAX));
                    MODE_EDIT_MIN:   state_next.edit_minute =
                                         step_down(state_reg.edit_minute, MINUTE_MAX);
                    MODE_EDIT_AHOUR: state_next.alarm_hour =
                                         5'(step_down({1'b0, state_reg.alarm_hour}, HOUR_MAX));
                    MODE_EDIT_AMIN:  state_next.alarm_minute =
                                         step_down(state_reg.alarm_minute, MINUTE_MAX);
                    default:         ;
                endcase
            end
            default: ;
        endcase
    end

    // state register, updated when the transaction moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    assign ctrl.st        = state_next;
    assign ctrl.rtc_write = wr;

endmodule

### rtl/acsd_render.sv
// acsd_render: builds the six segment codes and status fields for the new mode
module acsd_render
    import acsd_pkg::*;
(
    input  evt_t      evt,
    input  ctrl_out_t ctrl,
    output disp_t     disp
);

    logic [15:0] pair_lo;
    logic [15:0] pair_mid;
    logic [15:0] pair_hi;
    logic        dp;
    logic        alarm_scr;
    logic        hour_fld;
    logic [4:0]  hh;
    logic [5:0]  mm;
    logic [6:0]  temp_clamped;

    // screen composition
    always_comb
    begin
        dp           = ctrl.st.alarm_enabled;
        alarm_scr    = (ctrl.st.mode == MODE_EDIT_AHOUR) || (ctrl.st.mode == MODE_EDIT_AMIN);
        hour_fld     = (ctrl.st.mode == MODE_EDIT_HOUR) || (ctrl.st.mode == MODE_EDIT_AHOUR);
        hh           = alarm_scr ? ctrl.st.alarm_hour : ctrl.st.edit_hour;
        mm           = alarm_scr ? ctrl.st.alarm_minute : ctrl.st.edit_minute;
        temp_clamped = (evt.temperature > TEMP_MAX) ? TEMP_MAX : evt.temperature;

        disp = '0;
        case (ctrl.st.mode)
            MODE_TIME:
            begin
                pair_lo  = pair_codes(7'(evt.now_second), dp, 1'b0);
                pair_mid = pair_codes(7'(evt.now_minute), dp, 1'b0);
                pair_hi  = pair_codes(7'(evt.now_hour), dp, 1'b0);
            end
            MODE_ALARM:
            begin
                pair_lo  = pair_codes(7'd0, dp, 1'b0);
                pair_mid = pair_codes(7'(ctrl.st.alarm_minute), dp, 1'b0);
                pair_hi  = pair_codes(7'(ctrl.st.alarm_hour), dp, 1'b0);
            end
            MODE_TEMP:
            begin
                pair_lo  = {SEG_GLYPH_DEG, SEG_GLYPH_C};
                pair_mid = pair_codes(temp_clamped, 1'b0, 1'b0);
                pair_hi  = {SEG_BLANK, SEG_BLANK};
            end
            default:
            begin
                pair_lo  = pair_codes(7'd0, dp, 1'b0);
                pair_mid = pair_codes(7'(mm), dp, evt.blink_phase && !hour_fld);
                pair_hi  = pair_codes(7'(hh), dp, evt.blink_phase && hour_fld);
            end
        endcase

        disp.seg_0        = pair_lo[7:0];
        disp.seg_1        = pair_lo[15:8];
        disp.seg_2        = pair_mid[7:0];
        disp.seg_3        = pair_mid[15:8];
        disp.seg_4        = pair_hi[7:0];
        disp.seg_5        = pair_hi[15:8];
        disp.mode_now     = 3'(ctrl.st.mode);
        disp.alarm_armed  = ctrl.st.alarm_enabled;
        disp.rtc_write    = ctrl.rtc_write;
        disp.write_hour   = ctrl.rtc_write ? ctrl.st.edit_hour : 5'd0;
        disp.write_minute = ctrl.rtc_write ? ctrl.st.edit_minute : 6'd0;
    end

endmodule

### rtl/alarm_clock_set_and_display.sv
// alarm_clock_set_and_display: top level with input and result registers
//
//  channel   | signals                        | payload
//  ----------+--------------------------------+---------------------------
//  event in  | evt_valid / evt_ready / evt    | acsd_pkg::evt_t
//  display   | disp_valid / disp_ready / disp | acsd_pkg::disp_t
//
// one transaction per cycle sustained while disp_ready holds; the path runs through the
// input register, then controller update and rendering into the result register
// controller state changes on the edge the transaction enters the result register
// rst_n clears both valid flags and loads the reset mode and alarm settings
// a stalled result holds the input register; evt_ready drops only when both are full
module alarm_clock_set_and_display
    import acsd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  evt_valid,
    output logic  evt_ready,
    input  evt_t  evt,
    output logic  disp_valid,
    input  logic  disp_ready,
    output disp_t disp
);

    logic      evt_valid_reg;
    logic      evt_valid_next;
    evt_t      evt_reg;
    logic      disp_valid_reg;
    logic      disp_valid_next;
    disp_t     disp_reg;
    disp_t     disp_next;
    logic      advance;
    logic      fire;
    ctrl_out_t ctrl;

    // handshake
    assign advance   = !disp_valid_reg || disp_ready;
    assign fire      = evt_valid_reg && advance;
    assign evt_ready = !evt_valid_reg || advance;

    always_comb
    begin
        if (evt_valid && evt_ready)
        begin
            evt_valid_next = 1'b1;
        end
        else if (advance)
        begin
            evt_valid_next = 1'b0;
        end
        else
        begin
            evt_valid_next = evt_valid_reg;
        end
        disp_valid_next = advance ? evt_valid_reg : disp_valid_reg;
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg  <= 1'b0;
            disp_valid_reg <= 1'b0;
        end
        else
        begin
            evt_valid_reg  <= evt_valid_next;
            disp_valid_reg <= disp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (evt_valid && evt_ready)
        begin
            evt_reg <= evt;
        end
        if (fire)
        begin
            disp_reg <= disp_next;
        end
    end

    acsd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .evt   (evt_reg),
        .ctrl  (ctrl)
    );

    acsd_render u_render (
        .evt  (evt_reg),
        .ctrl (ctrl),
        .disp (disp_next)
    );

    assign disp_valid = disp_valid_reg;
    assign disp       = disp_reg;

`ifndef ASSERT_OFF
    // a time write only accompanies the return to the time screen
    a_write_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (disp_valid && disp.rtc_write) |-> (disp.mode_now == 3'(MODE_TIME)))
        else $error("rtc write outside time screen");

    // write fields are zero when no write is requested
    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (disp_valid && !disp.rtc_write) |-> (disp.write_hour == 5'd0 &&
                                             disp.write_minute == 6'd0))
        else $error("write fields not cleared");

    // input side stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !evt_ready |-> (disp_valid && !disp_ready))
        else $error("input stalled without output back-pressure");

    // temperature screen leaves the two left digits blank
    a_temp_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (disp_valid && disp.mode_now == 3'(MODE_TEMP)) |->
            (disp.seg_4 == SEG_BLANK && disp.seg_5 == SEG_BLANK))
        else $error("temperature screen left digits lit");
`endif

endmodule
